FILE: rtl/core/bcm_pkg.sv
// Shared types and constants for the blocking channel mailbox.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package bcm_pkg;

  // Default sizes, handed down from the top level
  localparam int RING_DEPTH_DEF = 16;
  localparam int NUM_REQ_DEF    = 8;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int REQ_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_RECV  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

  // Completion status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd2;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request word
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  requester;
    logic [DATA_W-1:0] data;
  } in_word_t;

  // Completion word
  typedef struct packed {
    logic [REQ_W-1:0]    target;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value_out;
    logic                last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the request word
    logic exec;       // commit the request and issue its first completion
    logic emit_hold;  // issue the held second completion
    logic drain_pop;  // wake the next parked requester after a close, receivers first
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;    // output register can take a word this cycle
    logic has_second;   // the request gives a second completion
    logic start_drain;  // request is a close with requesters parked
    logic drain_more;   // more than one requester still parked
  } dp_status_t;

endpackage

FILE: rtl/core/bcm_stream_if.sv
// Valid/ready stream interface carrying one payload word per handshake.
// Payload type is a parameter; the mailbox uses bcm_pkg word types.
`timescale 1ns / 1ps

interface bcm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/core/bcm_ctrl.sv
// Sequencing controller for the blocking channel mailbox.
// Drives dp_cmd_t to bcm_datapath and reads its dp_status_t; uses bcm_pkg.
`timescale 1ns / 1ps

module bcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output bcm_pkg::dp_cmd_t    cmd_o,
  input  bcm_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_SECOND,
    S_DRAIN_POP,
    S_DRAIN_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  assign in_ready_o = in_ready_q;

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.load      = in_ready_q & in_valid_i;
    case (state_q)
      S_IDLE: begin
        if (in_ready_q && in_valid_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // memory heads settle
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.slot_free) begin
          cmd_o.exec = 1'b1;
          if (status_i.has_second) begin
            state_d = S_SECOND;
          end else if (status_i.start_drain) begin
            state_d = S_DRAIN_POP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SECOND: begin
        if (status_i.slot_free) begin
          cmd_o.emit_hold = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DRAIN_POP: begin
        if (status_i.slot_free) begin
          cmd_o.drain_pop = 1'b1;
          state_d         = status_i.drain_more ? S_DRAIN_WAIT : S_IDLE;
        end
      end
      S_DRAIN_WAIT: begin
        // new queue head is being read
        state_d = S_DRAIN_POP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

endmodule

FILE: rtl/core/bcm_datapath.sv
// Datapath of the blocking channel mailbox: ring buffer, wait queues, parked values,
// waiting mask, capacity register and the output register. Uses bcm_pkg; driven by bcm_ctrl.
`timescale 1ns / 1ps

module bcm_datapath #(
  parameter int RING_DEPTH     = bcm_pkg::RING_DEPTH_DEF,
  parameter int NUM_REQUESTERS = bcm_pkg::NUM_REQ_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cap_we_i,
  input  logic [bcm_pkg::CAP_W-1:0]  cap_wdata_i,
  input  bcm_pkg::in_word_t          in_word_i,
  input  bcm_pkg::dp_cmd_t           cmd_i,
  output bcm_pkg::dp_status_t        status_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output bcm_pkg::out_word_t         out_word_o
);

  localparam int PW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int IDW  = $clog2(NUM_REQUESTERS);
  localparam int CNTW = IDW + 1;
  localparam int NW   = (PW + 1 > bcm_pkg::CAP_W) ? PW + 1 : bcm_pkg::CAP_W;

  typedef enum logic [3:0] {
    A_NONE,
    A_SEND_CLOSED,
    A_HANDOFF,
    A_SEND_BUF,
    A_BUSY,
    A_SEND_PARK,
    A_RECV_CLOSED,
    A_RECV_BUF,
    A_RECV_DIRECT,
    A_RECV_PARK,
    A_CLOSE
  } act_e;

  // Ring position after p, wrapping at the capacity in use
  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
                                              input logic [bcm_pkg::CAP_W-1:0] c);
    logic [NW-1:0] p1;
    begin
      p1 = NW'(p) + NW'(1);
      return (p1 >= NW'(c)) ? '0 : PW'(p1);
    end
  endfunction

  // Queue head advance
  function automatic logic [IDW-1:0] q_inc(input logic [IDW-1:0] h);
    begin
      return (h == IDW'(NUM_REQUESTERS - 1)) ? '0 : h + IDW'(1);
    end
  endfunction

  // Queue tail slot
  function automatic logic [IDW-1:0] q_tail(input logic [IDW-1:0] h, input logic [CNTW-1:0] c);
    logic [CNTW-1:0] s;
    begin
      s = CNTW'(h) + c;
      if (s >= CNTW'(NUM_REQUESTERS)) begin
        s = s - CNTW'(NUM_REQUESTERS);
      end
      return IDW'(s);
    end
  endfunction

  function automatic bcm_pkg::out_word_t mk_word(input logic [bcm_pkg::REQ_W-1:0] tgt,
                                                 input logic [bcm_pkg::STATUS_W-1:0] st,
                                                 input logic [bcm_pkg::DATA_W-1:0] val,
                                                 input logic lst);
    bcm_pkg::out_word_t w;
    begin
      w.target    = tgt;
      w.status    = st;
      w.value_out = val;
      w.last      = lst;
      return w;
    end
  endfunction

  // Control state
  logic [bcm_pkg::CAP_W-1:0] cap_q;
  logic [PW-1:0]             rd_ptr_q, wr_ptr_q;
  logic [bcm_pkg::CAP_W-1:0] fill_q;
  logic                      closed_q;
  logic [IDW-1:0]            s_head_q, r_head_q;
  logic [CNTW-1:0]           s_cnt_q, r_cnt_q;
  logic [NUM_REQUESTERS-1:0] waiting_q;
  logic                      out_valid_q;

  // Payload registers
  bcm_pkg::in_word_t  item_q;
  bcm_pkg::out_word_t out_word_q, hold_q;

  // Memories and their registered read data
  logic [bcm_pkg::DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [IDW-1:0]             s_mem    [NUM_REQUESTERS];
  logic [IDW-1:0]             r_mem    [NUM_REQUESTERS];
  logic [bcm_pkg::DATA_W-1:0] pv_mem   [NUM_REQUESTERS];
  logic [bcm_pkg::DATA_W-1:0] ring_rd_q, pv_rd_q;
  logic [IDW-1:0]             s_rd_q, r_rd_q;

  // Decode
  act_e                       act;
  logic [IDW-1:0]             rq;
  logic                       in_range, busy, s_any, r_any;
  logic [bcm_pkg::CAP_W-1:0]  eff_cap;
  logic [CNTW:0]              parked_sum;
  bcm_pkg::out_word_t         r1, r2, drain_w;
  logic                       has_r1, has_r2;
  logic                       ring_we, s_push, r_push, pv_we, load_out;
  logic [bcm_pkg::DATA_W-1:0] ring_wdata;

  assign rq         = IDW'(item_q.requester);
  assign in_range   = 32'(item_q.requester) < NUM_REQUESTERS;
  assign busy       = waiting_q[rq];
  assign s_any      = (s_cnt_q != '0);
  assign r_any      = (r_cnt_q != '0);
  assign eff_cap    = (32'(cap_q) > RING_DEPTH) ? bcm_pkg::CAP_W'(RING_DEPTH) : cap_q;
  assign parked_sum = (CNTW + 1)'(s_cnt_q) + (CNTW + 1)'(r_cnt_q);

  // Pick the action for the held request
  always_comb begin
    act = A_NONE;
    case (item_q.op)
      bcm_pkg::OP_SEND: begin
        if (closed_q) begin
          act = A_SEND_CLOSED;
        end else if (r_any) begin
          act = A_HANDOFF;
        end else if (eff_cap != '0 && fill_q < eff_cap) begin
          act = A_SEND_BUF;
        end else if (busy) begin
          act = A_BUSY;
        end else begin
          act = A_SEND_PARK;
        end
      end
      bcm_pkg::OP_RECV: begin
        if (closed_q && fill_q == '0 && !s_any) begin
          act = A_RECV_CLOSED;
        end else if (eff_cap != '0 && fill_q != '0) begin
          act = A_RECV_BUF;
        end else if (s_any) begin
          act = A_RECV_DIRECT;
        end else if (busy) begin
          act = A_BUSY;
        end else begin
          act = A_RECV_PARK;
        end
      end
      bcm_pkg::OP_CLOSE: begin
        act = closed_q ? A_NONE : A_CLOSE;
      end
      default: begin
        act = A_NONE;
      end
    endcase
    if (!in_range) begin
      act = A_NONE;
    end
  end

  // Build the completion words
  always_comb begin
    has_r1 = 1'b1;
    has_r2 = 1'b0;
    r1     = mk_word(item_q.requester, bcm_pkg::ST_OK, '0, 1'b1);
    r2     = mk_word(bcm_pkg::REQ_W'(s_rd_q), bcm_pkg::ST_OK, '0, 1'b1);
    case (act)
      A_SEND_CLOSED, A_RECV_CLOSED: begin
        r1 = mk_word(item_q.requester, bcm_pkg::ST_CLOSED, '0, 1'b1);
      end
      A_BUSY: begin
        r1 = mk_word(item_q.requester, bcm_pkg::ST_BUSY, '0, 1'b1);
      end
      A_HANDOFF: begin
        r1     = mk_word(bcm_pkg::REQ_W'(r_rd_q), bcm_pkg::ST_OK, item_q.data, 1'b0);
        r2     = mk_word(item_q.requester, bcm_pkg::ST_OK, '0, 1'b1);
        has_r2 = 1'b1;
      end
      A_SEND_BUF: begin
        r1 = mk_word(item_q.requester, bcm_pkg::ST_OK, '0, 1'b1);
      end
      A_RECV_BUF: begin
        r1     = mk_word(item_q.requester, bcm_pkg::ST_OK, ring_rd_q, !s_any);
        has_r2 = s_any;
      end
      A_RECV_DIRECT: begin
        r1     = mk_word(item_q.requester, bcm_pkg::ST_OK, pv_rd_q, 1'b0);
        has_r2 = 1'b1;
      end
      A_NONE, A_SEND_PARK, A_RECV_PARK, A_CLOSE: begin
        has_r1 = 1'b0;
      end
      default: begin
        has_r1 = 1'b0;
      end
    endcase
  end

  // Wake word during a close: receivers first, then senders
  assign drain_w = mk_word(r_any ? bcm_pkg::REQ_W'(r_rd_q) : bcm_pkg::REQ_W'(s_rd_q),
                           bcm_pkg::ST_CLOSED, '0, parked_sum <= (CNTW + 1)'(1));

  // Memory write controls
  assign ring_we    = cmd_i.exec && (act == A_SEND_BUF || (act == A_RECV_BUF && s_any));
  assign ring_wdata = (act == A_SEND_BUF) ? item_q.data : pv_rd_q;
  assign pv_we      = cmd_i.exec && (act == A_SEND_PARK);
  assign s_push     = pv_we && (s_cnt_q != CNTW'(NUM_REQUESTERS));
  assign r_push     = cmd_i.exec && (act == A_RECV_PARK) && (r_cnt_q != CNTW'(NUM_REQUESTERS));
  assign load_out   = (cmd_i.exec && has_r1) || cmd_i.emit_hold || cmd_i.drain_pop;

  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.has_second  = has_r2;
  assign status_o.start_drain = (act == A_CLOSE) && (r_any || s_any);
  assign status_o.drain_more  = parked_sum > (CNTW + 1)'(1);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_ptr_q] <= ring_wdata;
    end
    ring_rd_q <= ring_mem[rd_ptr_q];
  end

  // Wait queues and parked values
  always_ff @(posedge clk_i) begin
    if (s_push) begin
      s_mem[q_tail(s_head_q, s_cnt_q)] <= rq;
    end
    if (r_push) begin
      r_mem[q_tail(r_head_q, r_cnt_q)] <= rq;
    end
    if (pv_we) begin
      pv_mem[rq] <= item_q.data;
    end
    s_rd_q  <= s_mem[s_head_q];
    r_rd_q  <= r_mem[r_head_q];
    pv_rd_q <= pv_mem[s_rd_q];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.exec) begin
      out_word_q <= r1;
      hold_q     <= r2;
    end else if (cmd_i.emit_hold) begin
      out_word_q <= hold_q;
    end else if (cmd_i.drain_pop) begin
      out_word_q <= drain_w;
    end
  end

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= bcm_pkg::CAP_RESET;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      closed_q    <= 1'b0;
      s_head_q    <= '0;
      s_cnt_q     <= '0;
      r_head_q    <= '0;
      r_cnt_q     <= '0;
      waiting_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cap_we_i) begin
        cap_q <= cap_wdata_i;
      end

      // output register: load or drop when taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.exec) begin
        case (act)
          A_HANDOFF: begin
            r_head_q          <= q_inc(r_head_q);
            r_cnt_q           <= r_cnt_q - CNTW'(1);
            waiting_q[r_rd_q] <= 1'b0;
          end
          A_SEND_BUF: begin
            wr_ptr_q <= ring_next(wr_ptr_q, eff_cap);
            fill_q   <= fill_q + bcm_pkg::CAP_W'(1);
          end
          A_SEND_PARK: begin
            if (s_push) begin
              s_cnt_q       <= s_cnt_q + CNTW'(1);
              waiting_q[rq] <= 1'b1;
            end
          end
          A_RECV_BUF: begin
            rd_ptr_q <= ring_next(rd_ptr_q, eff_cap);
            if (s_any) begin
              // refill the ring from the oldest parked sender
              s_head_q          <= q_inc(s_head_q);
              s_cnt_q           <= s_cnt_q - CNTW'(1);
              waiting_q[s_rd_q] <= 1'b0;
              wr_ptr_q          <= ring_next(wr_ptr_q, eff_cap);
            end else begin
              fill_q <= fill_q - bcm_pkg::CAP_W'(1);
            end
          end
          A_RECV_DIRECT: begin
            s_head_q          <= q_inc(s_head_q);
            s_cnt_q           <= s_cnt_q - CNTW'(1);
            waiting_q[s_rd_q] <= 1'b0;
          end
          A_RECV_PARK: begin
            if (r_push) begin
              r_cnt_q       <= r_cnt_q + CNTW'(1);
              waiting_q[rq] <= 1'b1;
            end
          end
          A_CLOSE: begin
            closed_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      // wake one parked requester per pop
      if (cmd_i.drain_pop) begin
        if (r_any) begin
          r_head_q          <= q_inc(r_head_q);
          r_cnt_q           <= r_cnt_q - CNTW'(1);
          waiting_q[r_rd_q] <= 1'b0;
        end else begin
          s_head_q          <= q_inc(s_head_q);
          s_cnt_q           <= s_cnt_q - CNTW'(1);
          waiting_q[s_rd_q] <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/blocking_channel_mailbox.sv
// Blocking channel mailbox: send, receive and close requests from numbered requesters come
// in one word at a time on cmd_i and complete on cpl_o. A request is taken only while the
// block is idle. Each request waits in a settle state after it is loaded, since the registered
// read chain from the wait queue head to the parked-value memory must settle before the request
// is committed; a request that gives two completions issues the second from a held register.
// A close that wakes parked requesters issues one wake word per requester woken, receivers
// first, and between words reads the new queue head. A stall on cpl_o with a word still held
// holds the sequence. No clearing pass is needed after reset. The capacity register may be
// written only while the block is idle; values above RING_DEPTH act as RING_DEPTH and 0
// selects direct handoff.
`timescale 1ns / 1ps

module blocking_channel_mailbox #(
  parameter int RING_DEPTH     = bcm_pkg::RING_DEPTH_DEF,
  parameter int NUM_REQUESTERS = bcm_pkg::NUM_REQ_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bcm_pkg::CAP_W-1:0] cfg_wdata_i,
  bcm_stream_if.sink                cmd_i,
  bcm_stream_if.source              cpl_o
);

  bcm_pkg::dp_cmd_t    dp_cmd;
  bcm_pkg::dp_status_t dp_status;
  bcm_pkg::out_word_t  out_word;
  logic                in_ready;
  logic                out_valid;

  assign cmd_i.ready   = in_ready;
  assign cpl_o.valid   = out_valid;
  assign cpl_o.payload = out_word;

  bcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (dp_cmd),
    .status_i   (dp_status)
  );

  bcm_datapath #(
    .RING_DEPTH     (RING_DEPTH),
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_we_i    (cfg_we_i),
    .cap_wdata_i (cfg_wdata_i),
    .in_word_i   (cmd_i.payload),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_ready_i (cpl_o.ready),
    .out_valid_o (out_valid),
    .out_word_o  (out_word)
  );

endmodule

FILE: rtl/core/bcm_checker.sv
// Port-level checks for blocking_channel_mailbox, attached by the bind below.
// Uses bcm_pkg for the completion word and status codes.
`timescale 1ns / 1ps

module bcm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bcm_pkg::out_word_t out_word_i
);

  // Hold a stalled completion word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("completion word changed while stalled");

  // One request at a time: drop ready after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready held after accepting a request");

  // No new request while a request still owes completions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.last |-> !in_ready_i)
    else $error("request taken before the previous one finished");

  // Only an ok completion carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.status != bcm_pkg::ST_OK |-> out_word_i.value_out == '0)
    else $error("non-ok completion carries a value");

endmodule

bind blocking_channel_mailbox bcm_checker u_bcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (cpl_o.valid),
  .out_ready_i (cpl_o.ready),
  .out_word_i  (cpl_o.payload)
);

FILE: tb/sv/tb_blocking_channel_mailbox.sv
// Self-checking testbench for the blocking channel mailbox: a channel model predicts every
// completion word, tasks drive requests and capacity writes, and a sink drives back-pressure.
// Depends on bcm_pkg, bcm_stream_if and blocking_channel_mailbox.
`timescale 1ns / 1ps

// Channel model: mirrors ring, wait queues and close state, holds the completions still due
class channel_model;
  logic [bcm_pkg::CAP_W-1:0]  cap_reg;
  logic [bcm_pkg::DATA_W-1:0] ring [bcm_pkg::RING_DEPTH_DEF];
  int unsigned                rd_ptr, wr_ptr, fill;
  bit                         closed;
  logic [bcm_pkg::REQ_W-1:0]  snd_q[$];
  logic [bcm_pkg::REQ_W-1:0]  rcv_q[$];
  logic [bcm_pkg::DATA_W-1:0] parked_val [bcm_pkg::NUM_REQ_DEF];
  bit                         waiting [bcm_pkg::NUM_REQ_DEF];
  bcm_pkg::out_word_t         due_q[$];
  int unsigned                failures, results_seen;

  function new();
    cap_reg = bcm_pkg::CAP_RESET;
    rd_ptr = 0;
    wr_ptr = 0;
    fill = 0;
    closed = 0;
    failures = 0;
    results_seen = 0;
    foreach (ring[i]) ring[i] = '0;
    foreach (waiting[i]) begin
      waiting[i] = 0;
      parked_val[i] = '0;
    end
  endfunction

  function int unsigned ring_size();
    return (cap_reg > bcm_pkg::RING_DEPTH_DEF) ? bcm_pkg::RING_DEPTH_DEF : cap_reg;
  endfunction

  function int unsigned advance(int unsigned p, int unsigned c);
    return (p + 1 >= c) ? 0 : p + 1;
  endfunction

  // True when a new capacity keeps every later ring read on a written entry
  function bit capacity_safe(logic [bcm_pkg::CAP_W-1:0] v);
    int unsigned c;
    c = (v > bcm_pkg::RING_DEPTH_DEF) ? bcm_pkg::RING_DEPTH_DEF : v;
    if (fill == 0 && rd_ptr == wr_ptr) return 1;
    if (c == 0) return 1;
    return rd_ptr < c && wr_ptr < c && fill <= c && (rd_ptr + fill) % c == wr_ptr;
  endfunction

  function void complete(logic [bcm_pkg::REQ_W-1:0] tgt, logic [bcm_pkg::STATUS_W-1:0] st,
                         logic [bcm_pkg::DATA_W-1:0] val);
    bcm_pkg::out_word_t w;
    w.target = tgt;
    w.status = st;
    w.value_out = val;
    w.last = 1'b0;
    due_q.push_back(w);
  endfunction

  // Apply one accepted request word and queue the completions it causes
  function void note_request(bcm_pkg::in_word_t w);
    int unsigned               c, n0;
    logic [bcm_pkg::REQ_W-1:0] r, peer;
    bcm_pkg::out_word_t        tail;
    c = ring_size();
    n0 = due_q.size();
    r = w.requester;
    case (w.op)
      bcm_pkg::OP_SEND: begin
        if (closed) begin
          complete(r, bcm_pkg::ST_CLOSED, '0);
        end else if (rcv_q.size() > 0) begin
          // hand the value straight to the oldest parked receiver
          peer = rcv_q.pop_front();
          waiting[peer] = 0;
          complete(peer, bcm_pkg::ST_OK, w.data);
          complete(r, bcm_pkg::ST_OK, '0);
        end else if (c > 0 && fill < c) begin
          ring[wr_ptr] = w.data;
          wr_ptr = advance(wr_ptr, c);
          fill++;
          complete(r, bcm_pkg::ST_OK, '0);
        end else if (waiting[r]) begin
          complete(r, bcm_pkg::ST_BUSY, '0);
        end else begin
          parked_val[r] = w.data;
          snd_q.push_back(r);
          waiting[r] = 1;
        end
      end
      bcm_pkg::OP_RECV: begin
        if (closed && fill == 0 && snd_q.size() == 0) begin
          complete(r, bcm_pkg::ST_CLOSED, '0);
        end else if (c > 0 && fill > 0) begin
          // take the oldest ring entry, then refill from the oldest parked sender
          complete(r, bcm_pkg::ST_OK, ring[rd_ptr]);
          rd_ptr = advance(rd_ptr, c);
          fill--;
          if (snd_q.size() > 0) begin
            peer = snd_q.pop_front();
            waiting[peer] = 0;
            ring[wr_ptr] = parked_val[peer];
            wr_ptr = advance(wr_ptr, c);
            fill++;
            complete(peer, bcm_pkg::ST_OK, '0);
          end
        end else if (snd_q.size() > 0) begin
          peer = snd_q.pop_front();
          waiting[peer] = 0;
          complete(r, bcm_pkg::ST_OK, parked_val[peer]);
          complete(peer, bcm_pkg::ST_OK, '0);
        end else if (waiting[r]) begin
          complete(r, bcm_pkg::ST_BUSY, '0);
        end else begin
          rcv_q.push_back(r);
          waiting[r] = 1;
        end
      end
      bcm_pkg::OP_CLOSE: begin
        // wake receivers first, then senders, oldest first
        if (!closed) begin
          closed = 1;
          while (rcv_q.size() > 0) begin
            peer = rcv_q.pop_front();
            waiting[peer] = 0;
            complete(peer, bcm_pkg::ST_CLOSED, '0);
          end
          while (snd_q.size() > 0) begin
            peer = snd_q.pop_front();
            waiting[peer] = 0;
            complete(peer, bcm_pkg::ST_CLOSED, '0);
          end
        end
      end
      default: ;
    endcase
    // mark the final word of this request
    if (due_q.size() > n0) begin
      tail = due_q.pop_back();
      tail.last = 1'b1;
      due_q.push_back(tail);
    end
  endfunction

  // Compare one accepted completion word with the oldest one due
  function void check_result(bcm_pkg::out_word_t got);
    bcm_pkg::out_word_t want;
    results_seen++;
    if (due_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("completion with none due: target %0d status %0d value %08h last %0d",
                 got.target, got.status, got.value_out, got.last);
    end else begin
      want = due_q.pop_front();
      if (got.target !== want.target || got.status !== want.status ||
          got.value_out !== want.value_out || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("completion mismatch: expected t%0d s%0d %08h l%0d, got t%0d s%0d %08h l%0d",
                   want.target, want.status, want.value_out, want.last,
                   got.target, got.status, got.value_out, got.last);
      end
    end
  endfunction
endclass

module tb_blocking_channel_mailbox;
  import bcm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int              SETTLE    = 20;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  bit               no_idle = 0;
  channel_model     sb;

  bcm_stream_if #(.payload_t(in_word_t))  cmd_if ();
  bcm_stream_if #(.payload_t(out_word_t)) cpl_if ();

  blocking_channel_mailbox uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_if),
    .cpl_o       (cpl_if)
  );

  always #5 clk_i = ~clk_i;

  // Check every completion word taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_ni && cpl_if.valid && cpl_if.ready) begin
      sb.check_result(cpl_if.payload);
    end
  end

  // Completion side: random stalls, and one long hold-off so the block backs up
  initial begin : cpl_sink
    bit held;
    held = 0;
    cpl_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sb.results_seen >= 80) begin
        held = 1;
        cpl_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      cpl_if.ready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [DATA_W-1:0] pick_data();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Offer one request word; starts and returns at a falling edge with valid still high
  task automatic push_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                              input logic [DATA_W-1:0] data);
    in_word_t w;
    w.op = op;
    w.requester = req;
    w.data = data;
    while (!no_idle && $urandom_range(99) < 12) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= w;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_request(w);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every due completion has come and the block has settled
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cap_reg = v;
  endtask

  // Empty the ring first, then change capacity only if no stale read can follow
  task automatic set_capacity_safely(input logic [CAP_W-1:0] v);
    while (sb.fill > 0 && sb.ring_size() > 0)
      push_request(OP_RECV, REQ_W'($urandom_range(7)), pick_data());
    if (sb.capacity_safe(v)) write_capacity(v);
    else wait_idle();
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned send_pct,
                           input logic [CAP_W-1:0] v);
    int unsigned k;
    logic [REQ_W-1:0] req;
    set_capacity_safely(v);
    k = 0;
    while (k < n) begin
      req = REQ_W'($urandom_range(7));
      if ($urandom_range(99) < 3) begin
        push_request(OP_UNUSED, req, pick_data());
      end else begin
        push_request(($urandom_range(99) < send_pct) ? OP_SEND : OP_RECV, req, pick_data());
        k++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned      k, roll;
    logic [REQ_W-1:0] req;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.payload = '0;
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: parking, already waiting, self handoff, ring use at reset capacity
    push_request(OP_RECV, 3'd0, 32'h0000_0000);
    push_request(OP_RECV, 3'd0, 32'hFFFF_FFFF);
    push_request(OP_SEND, 3'd0, 32'hFFFF_FFFF);
    push_request(OP_SEND, 3'd1, 32'h0000_0000);
    push_request(OP_SEND, 3'd7, 32'hA5A5_A5A5);
    push_request(OP_SEND, 3'd2, 32'h5A5A_5A5A);
    push_request(OP_RECV, 3'd3, 32'h0000_0000);

    // Directed: unbuffered handoff with words still held in the ring
    write_capacity(5'd0);
    push_request(OP_SEND, 3'd4, 32'h1234_5678);
    push_request(OP_SEND, 3'd4, 32'h8765_4321);
    push_request(OP_RECV, 3'd5, 32'hFFFF_FFFF);
    push_request(OP_RECV, 3'd6, 32'h0000_0000);
    push_request(OP_SEND, 3'd2, 32'hDEAD_BEEF);
    push_request(OP_UNUSED, 3'd7, 32'hFFFF_FFFF);

    // Directed: raise capacity to reach the held words, fill, park senders, refill
    write_capacity(5'd4);
    push_request(OP_RECV, 3'd3, 32'h0000_0000);
    push_request(OP_SEND, 3'd5, 32'h8000_0001);
    push_request(OP_SEND, 3'd6, 32'h7FFF_FFFE);
    push_request(OP_SEND, 3'd7, 32'h0000_FFFF);
    push_request(OP_SEND, 3'd0, 32'hFFFF_0000);
    push_request(OP_SEND, 3'd1, 32'h1357_9BDF);
    push_request(OP_RECV, 3'd2, 32'h0000_0000);
    push_request(OP_RECV, 3'd1, 32'h0000_0000);

    // Random phases over several capacities, one of them with no idling at all
    run_phase(40, 60, 5'd31);
    run_phase(40, 50, 5'd1);
    no_idle = 1;
    run_phase(40, 50, 5'd0);
    no_idle = 0;
    run_phase(40, 65, 5'd2);
    run_phase(40, 55, 5'd16);
    run_phase(40, 45, CAP_W'($urandom_range(15, 1)));

    // Park every requester, then close so that a single close wakes all of them
    wait_idle();
    while (sb.snd_q.size() + sb.rcv_q.size() < NUM_REQ_DEF) begin
      do req = REQ_W'($urandom_range(7)); while (sb.waiting[req]);
      push_request(OP_SEND, req, pick_data());
    end
    push_request(OP_CLOSE, REQ_W'($urandom_range(7)), pick_data());

    // Closed channel: drain buffered words, refuse sends, ignore repeated closes
    k = 0;
    while (k < 24) begin
      roll = $urandom_range(99);
      req = REQ_W'($urandom_range(7));
      if (roll < 5) begin
        push_request(OP_UNUSED, req, pick_data());
      end else begin
        push_request((roll < 45) ? OP_SEND : (roll < 90) ? OP_RECV : OP_CLOSE, req,
                     pick_data());
        k++;
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.due_q.size() != 0)
        $display("%0d completion words never arrived", sb.due_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bcm_pkg.sv
rtl/core/bcm_stream_if.sv
rtl/core/bcm_ctrl.sv
rtl/core/bcm_datapath.sv
rtl/core/blocking_channel_mailbox.sv
rtl/core/bcm_checker.sv
tb/sv/tb_blocking_channel_mailbox.sv
